// File: rtl/ccq_pkg.sv
// Shared types and constants for the command queue.
// Holds the stored instruction layout, command and opcode codes and the state codes.
// No dependencies; used by every other file of the block.
package ccq_pkg;

  // Stored instruction: type, aux opcode and opaque body.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  opcode;
    logic [47:0] payload;
  } entry_t;

  // Commands carried by one input item.
  typedef enum logic [1:0] {
    CMD_RECEIVE  = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_RETIRE   = 2'd2,
    CMD_POLL     = 2'd3
  } command_t;

  // Instruction type and aux opcodes with a meaning to the queue.
  localparam logic [1:0] KIND_AUX = 2'd2;
  localparam logic [3:0] OP_START = 4'd1;
  localparam logic [3:0] OP_END   = 4'd2;
  localparam logic [3:0] OP_ABORT = 4'd3;

  // Reset value of the low-water register.
  localparam logic [4:0] LOW_WATER_RESET = 5'd8;

  // Sequencer states: take an item, or wait for the ring read.
  typedef enum logic [1:0] {
    S_RUN   = 2'b01,
    S_FETCH = 2'b10
  } state_t;

endpackage

// File: rtl/cnc_command_queue.sv
// Command queue for a motion controller: top level with sequencer and flags.
// Instantiates ccq_ring for the program ring; types and codes from ccq_pkg.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one command per item:
//   receive, dispatch, retire or refill poll, with the instruction fields and
//   the link and busy status bits. Each accepted item yields exactly one
//   result item on the result channel (res_valid / res_stall), which shows
//   the current instruction, the fill level, the program flags and the
//   per-command event flags.
//   Result timing: a result appears in the cycle after its item is accepted,
//   except a dispatch that takes the ring head, which first passes the fetch
//   state to wait for the ring memory's registered read.
//   Throughput: one item per cycle while the receiver does not stall; a ring
//   dispatch also holds off items during the fetch state for the memory read.
//   The low-water register is written through cfg_wr_en / cfg_wr_data, by the user
//   only while the block is idle (the block itself does not enforce it); it resets to 8.
//   Reset (rst, synchronous) empties the queue and the instant slot and
//   drops any pending result. The ring contents are not cleared; entries are
//   read only while counted as held.
//   When the receiver stalls, the result is held unchanged and the block
//   stops taking items until it is taken.
module cnc_command_queue #(
  parameter int QUEUE_DEPTH = 16,
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration port.
  input  logic             cfg_wr_en,
  input  logic [4:0]       cfg_wr_data,
  // Input channel.
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       command,
  input  logic             instant,
  input  logic [1:0]       kind,
  input  logic [3:0]       opcode,
  input  logic [47:0]      payload,
  input  logic             link_idle,
  input  logic             send_ok,
  input  logic             still_busy,
  // Result channel.
  output logic             res_valid,
  input  logic             res_stall,
  output logic             out_valid,
  output logic             out_instant,
  output logic [1:0]       out_kind,
  output logic [3:0]       out_opcode,
  output logic [47:0]      out_payload,
  output logic [CNT_W-1:0] fill_level,
  output logic             running_flag,
  output logic             received_flag,
  output logic             send_request,
  output logic             instant_done,
  output logic             underflow,
  output logic             overflow
);

  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  // Control and state registers.
  ccq_pkg::state_t  state, state_next;
  logic [4:0]       low_water;
  logic [IDX_W-1:0] write_index, write_index_next;
  logic [IDX_W-1:0] read_index, read_index_next;
  logic [CNT_W-1:0] fill_count, fill_count_next;
  ccq_pkg::entry_t  instant_entry, instant_entry_next;
  logic             instant_valid, instant_valid_next;
  ccq_pkg::entry_t  current_entry, current_entry_next;
  logic             current_valid, current_valid_next;
  logic             current_from_instant, current_from_instant_next;
  logic             program_active, program_active_next;
  logic             program_closed, program_closed_next;
  logic             refill_wanted, refill_wanted_next;
  logic             request_pending, request_pending_next;
  logic             res_valid_next;

  // Per-item event flags.
  logic send_request_next, instant_done_next, underflow_next, overflow_next;

  // Ring access.
  logic            ring_wr_en, ring_rd_en;
  ccq_pkg::entry_t ring_rd_data;
  ccq_pkg::entry_t in_entry;
  ccq_pkg::command_t cmd;
  logic            accept, is_aux, ring_full, below_water;

  assign in_entry    = '{kind: kind, opcode: opcode, payload: payload};
  assign cmd         = ccq_pkg::command_t'(command);
  assign is_aux      = (kind == ccq_pkg::KIND_AUX);
  assign ring_full   = (fill_count == FULL_CNT);
  assign below_water = (CMP_W'(fill_count) <= CMP_W'(low_water));

  // Items are refused during the ring read and while a result waits.
  assign in_stall = (state == ccq_pkg::S_FETCH) || (res_valid && res_stall);
  assign accept   = in_valid && !in_stall;

  ccq_ring #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ring_wr_en),
    .wr_addr (write_index),
    .wr_data (in_entry),
    .rd_en   (ring_rd_en),
    .rd_addr (read_index),
    .rd_data (ring_rd_data)
  );

  // Command decode: read, modify and write back the queue state.
  always_comb begin
    state_next                = state;
    write_index_next          = write_index;
    read_index_next           = read_index;
    fill_count_next           = fill_count;
    instant_entry_next        = instant_entry;
    instant_valid_next        = instant_valid;
    current_entry_next        = current_entry;
    current_valid_next        = current_valid;
    current_from_instant_next = current_from_instant;
    program_active_next       = program_active;
    program_closed_next       = program_closed;
    refill_wanted_next        = refill_wanted;
    request_pending_next      = request_pending;
    send_request_next         = 1'b0;
    instant_done_next         = 1'b0;
    underflow_next            = 1'b0;
    overflow_next             = 1'b0;
    ring_wr_en                = 1'b0;
    ring_rd_en                = 1'b0;
    res_valid_next            = res_valid && res_stall;

    unique case (state)
      ccq_pkg::S_FETCH: begin
        // The ring head arrives from memory and becomes current.
        current_entry_next = ring_rd_data;
        res_valid_next     = 1'b1;
        state_next         = ccq_pkg::S_RUN;
      end
      ccq_pkg::S_RUN: begin
        if (accept) begin
          res_valid_next = 1'b1;
          case (cmd)
            ccq_pkg::CMD_RECEIVE: begin
              if (instant) begin
                // Instant slot: fill when free; a busy one turns into an abort on an abort item.
                if (!instant_valid) begin
                  instant_entry_next = in_entry;
                  instant_valid_next = 1'b1;
                end else if (is_aux && opcode == ccq_pkg::OP_ABORT) begin
                  instant_entry_next.kind   = ccq_pkg::KIND_AUX;
                  instant_entry_next.opcode = ccq_pkg::OP_ABORT;
                  if (current_valid && current_from_instant) begin
                    current_entry_next = instant_entry_next;
                  end
                end
              end else begin
                request_pending_next = 1'b0;
                if (program_active) begin
                  if (ring_full) begin
                    overflow_next = 1'b1;
                  end else begin
                    ring_wr_en       = 1'b1;
                    write_index_next = (write_index == LAST_IDX) ? '0 : write_index + 1'b1;
                    fill_count_next  = fill_count + 1'b1;
                    if (is_aux && opcode == ccq_pkg::OP_END) begin
                      program_closed_next = 1'b1;
                      program_active_next = 1'b0;
                    end
                  end
                end else if (is_aux && opcode == ccq_pkg::OP_START) begin
                  // Start of a program empties the queue; the instant slot stays.
                  write_index_next          = '0;
                  read_index_next           = '0;
                  fill_count_next           = '0;
                  current_valid_next        = 1'b0;
                  current_from_instant_next = 1'b0;
                  current_entry_next        = '0;
                  program_active_next       = 1'b1;
                  program_closed_next       = 1'b0;
                  refill_wanted_next        = 1'b0;
                  request_pending_next      = 1'b0;
                end
              end
            end
            ccq_pkg::CMD_DISPATCH: begin
              // Instant slot first, then the ring head through a memory read.
              if (!current_valid) begin
                if (instant_valid) begin
                  current_entry_next        = instant_entry;
                  current_valid_next        = 1'b1;
                  current_from_instant_next = 1'b1;
                end else if (fill_count != '0) begin
                  ring_rd_en                = 1'b1;
                  read_index_next           = (read_index == LAST_IDX) ? '0 : read_index + 1'b1;
                  current_valid_next        = 1'b1;
                  current_from_instant_next = 1'b0;
                  res_valid_next            = 1'b0;
                  state_next                = ccq_pkg::S_FETCH;
                end else begin
                  underflow_next = 1'b1;
                end
              end
            end
            ccq_pkg::CMD_RETIRE: begin
              if (current_valid && !still_busy) begin
                current_valid_next = 1'b0;
                if (current_from_instant) begin
                  instant_valid_next = 1'b0;
                  instant_entry_next = '0;
                  instant_done_next  = 1'b1;
                end else if (fill_count != '0) begin
                  fill_count_next = fill_count - 1'b1;
                end
                current_from_instant_next = 1'b0;
                current_entry_next        = '0;
              end
            end
            default: begin
              // Refill poll: raise at or below low water, offer to the link, drop when full or no open program.
              if (program_active && !program_closed) begin
                if (refill_wanted) begin
                  if (ring_full) begin
                    refill_wanted_next = 1'b0;
                  end else if (!request_pending && link_idle) begin
                    send_request_next = 1'b1;
                    if (send_ok) begin
                      request_pending_next = 1'b1;
                    end
                  end
                end else if (below_water) begin
                  refill_wanted_next = 1'b1;
                end
              end else begin
                refill_wanted_next = 1'b0;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = ccq_pkg::S_RUN;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= ccq_pkg::S_RUN;
      low_water            <= ccq_pkg::LOW_WATER_RESET;
      write_index          <= '0;
      read_index           <= '0;
      fill_count           <= '0;
      instant_entry        <= '0;
      instant_valid        <= 1'b0;
      current_entry        <= '0;
      current_valid        <= 1'b0;
      current_from_instant <= 1'b0;
      program_active       <= 1'b0;
      program_closed       <= 1'b0;
      refill_wanted        <= 1'b0;
      request_pending      <= 1'b0;
      res_valid            <= 1'b0;
    end else begin
      state                <= state_next;
      if (cfg_wr_en) begin
        low_water <= cfg_wr_data;
      end
      write_index          <= write_index_next;
      read_index           <= read_index_next;
      fill_count           <= fill_count_next;
      instant_entry        <= instant_entry_next;
      instant_valid        <= instant_valid_next;
      current_entry        <= current_entry_next;
      current_valid        <= current_valid_next;
      current_from_instant <= current_from_instant_next;
      program_active       <= program_active_next;
      program_closed       <= program_closed_next;
      refill_wanted        <= refill_wanted_next;
      request_pending      <= request_pending_next;
      res_valid            <= res_valid_next;
    end
  end

  // Event flags of the item; they change only when an item is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      send_request <= send_request_next;
      instant_done <= instant_done_next;
      underflow    <= underflow_next;
      overflow     <= overflow_next;
    end
  end

  // The result shows the queue state directly; it only moves with an accepted item.
  assign out_valid     = current_valid;
  assign out_instant   = current_valid && current_from_instant;
  assign out_kind      = current_valid ? current_entry.kind : 2'd0;
  assign out_opcode    = current_valid ? current_entry.opcode : 4'd0;
  assign out_payload   = current_valid ? current_entry.payload : 48'd0;
  assign fill_level    = fill_count;
  assign running_flag  = program_active;
  assign received_flag = program_closed;

  // The fill count never passes the ring depth.
  assert property (@(posedge clk) disable iff (rst) CMP_W'(fill_count) <= CMP_W'(FULL_CNT))
    else $error("fill count above ring depth");

  // A ring read is only in flight after a dispatch item was taken.
  assert property (@(posedge clk) disable iff (rst)
    state == ccq_pkg::S_FETCH |-> $past(accept) && $past(cmd) == ccq_pkg::CMD_DISPATCH)
    else $error("ring read without a dispatch");

  // A dropped push is reported only against a full ring.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> fill_count == FULL_CNT)
    else $error("overflow with room in the ring");

  // After an instant retire the slot is free.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && instant_done |-> !instant_valid && !current_valid)
    else $error("instant slot still held after retire");

  // A program is never open and closed at once.
  assert property (@(posedge clk) disable iff (rst) !(program_active && program_closed))
    else $error("program both running and received");

endmodule

// File: rtl/ccq_ring.sv
// Ring memory for program instructions: one write port, one read port.
// Synchronous write; read data is registered, loaded while the read enable is high.
// Depends on ccq_pkg for the entry layout.
module ccq_ring #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  ccq_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output ccq_pkg::entry_t rd_data
);

  ccq_pkg::entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: tb/cnc_command_queue_tb.sv
// Self-checking testbench for the cnc_command_queue command queue.
// Drives a directed table and then random command traffic, checking each result item
// against a built-in predictor or a typed-in result; depends only on ccq_pkg and the RTL.
`timescale 1ns / 100ps

module cnc_command_queue_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [4:0] RING_DEPTH = 5'd16;
  localparam logic [47:0] ALL_ONES = {48{1'b1}};

  // One command item as offered on the input channel.
  typedef struct packed {
    ccq_pkg::command_t cmd;
    logic        inst;
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [47:0] pay;
    logic        idle;
    logic        ok;
    logic        busy;
  } queue_cmd_t;

  // One result item: current instruction, queue flags and event flags.
  typedef struct packed {
    logic        valid;
    logic        inst;
    logic [1:0]  kind;
    logic [3:0]  op;
    logic [47:0] pay;
    logic [4:0]  fill;
    logic        running;
    logic        received;
    logic        send_req;
    logic        inst_done;
    logic        under;
    logic        over;
  } queue_status_t;

  // A row of the directed table, optionally with its result typed in.
  typedef struct packed {
    queue_cmd_t    c;
    logic          fixed;
    queue_status_t want;
  } table_row_t;

  // Traffic shapes for the random part.
  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic        instant = 1'b0;
  logic [1:0]  kind = '0;
  logic [3:0]  opcode = '0;
  logic [47:0] payload = '0;
  logic        link_idle = 1'b0;
  logic        send_ok = 1'b0;
  logic        still_busy = 1'b0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        out_valid;
  logic        out_instant;
  logic [1:0]  out_kind;
  logic [3:0]  out_opcode;
  logic [47:0] out_payload;
  logic [4:0]  fill_level;
  logic        running_flag;
  logic        received_flag;
  logic        send_request;
  logic        instant_done;
  logic        underflow;
  logic        overflow;

  int errors = 0;
  int cycle_count = 0;
  queue_status_t expected_status[$];
  table_row_t stimulus_table[$];

  // Predictor copy of the queue state.
  logic [4:0]      lw_model = ccq_pkg::LOW_WATER_RESET;
  ccq_pkg::entry_t ring [16];
  logic [3:0]      wr_ptr = '0;
  logic [3:0]      rd_ptr = '0;
  logic [4:0]      held = '0;
  ccq_pkg::entry_t slot = '0;
  logic            slot_full = 1'b0;
  ccq_pkg::entry_t cur = '0;
  logic            cur_valid = 1'b0;
  logic            cur_instant = 1'b0;
  logic            prog_open = 1'b0;
  logic            prog_closed = 1'b0;
  logic            refill_wanted = 1'b0;
  logic            refill_sent = 1'b0;

  cnc_command_queue DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .instant      (instant),
    .kind         (kind),
    .opcode       (opcode),
    .payload      (payload),
    .link_idle    (link_idle),
    .send_ok      (send_ok),
    .still_busy   (still_busy),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_valid    (out_valid),
    .out_instant  (out_instant),
    .out_kind     (out_kind),
    .out_opcode   (out_opcode),
    .out_payload  (out_payload),
    .fill_level   (fill_level),
    .running_flag (running_flag),
    .received_flag(received_flag),
    .send_request (send_request),
    .instant_done (instant_done),
    .underflow    (underflow),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit; a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cnc_command_queue_tb: done, errors");
      $finish;
    end
  end

  function automatic queue_cmd_t make_cmd(ccq_pkg::command_t cmd, int inst, logic [1:0] k,
                                          logic [3:0] op, logic [47:0] pay,
                                          int idle, int ok, int busy);
    queue_cmd_t c;
    c.cmd = cmd;
    c.inst = 1'(inst);
    c.kind = k;
    c.op = op;
    c.pay = pay;
    c.idle = 1'(idle);
    c.ok = 1'(ok);
    c.busy = 1'(busy);
    return c;
  endfunction

  // Advances the predictor by one command and returns the result item it implies.
  function automatic queue_status_t apply_command(queue_cmd_t c);
    queue_status_t s;
    ccq_pkg::entry_t e;
    logic is_aux;
    s = '0;
    e.kind = c.kind;
    e.opcode = c.op;
    e.payload = c.pay;
    is_aux = (c.kind == ccq_pkg::KIND_AUX);
    case (c.cmd)
      ccq_pkg::CMD_RECEIVE: begin
        if (c.inst) begin
          // A busy instant slot only takes an abort, which keeps the body.
          if (!slot_full) begin
            slot = e;
            slot_full = 1'b1;
          end else if (is_aux && c.op == ccq_pkg::OP_ABORT) begin
            slot.kind = ccq_pkg::KIND_AUX;
            slot.opcode = ccq_pkg::OP_ABORT;
            if (cur_valid && cur_instant) cur = slot;
          end
        end else begin
          refill_sent = 1'b0;
          if (prog_open) begin
            if (held == RING_DEPTH) begin
              s.over = 1'b1;
            end else begin
              ring[wr_ptr] = e;
              wr_ptr = wr_ptr + 4'd1;
              held = held + 5'd1;
              if (is_aux && c.op == ccq_pkg::OP_END) begin
                prog_closed = 1'b1;
                prog_open = 1'b0;
              end
            end
          end else if (is_aux && c.op == ccq_pkg::OP_START) begin
            // A new program drops everything except the instant slot.
            wr_ptr = '0;
            rd_ptr = '0;
            held = '0;
            cur_valid = 1'b0;
            cur_instant = 1'b0;
            cur = '0;
            prog_closed = 1'b0;
            refill_wanted = 1'b0;
            refill_sent = 1'b0;
            prog_open = 1'b1;
          end
        end
      end
      ccq_pkg::CMD_DISPATCH: begin
        if (!cur_valid) begin
          if (slot_full) begin
            cur = slot;
            cur_valid = 1'b1;
            cur_instant = 1'b1;
          end else if (held != 0) begin
            cur = ring[rd_ptr];
            rd_ptr = rd_ptr + 4'd1;
            cur_valid = 1'b1;
            cur_instant = 1'b0;
          end else begin
            s.under = 1'b1;
          end
        end
      end
      ccq_pkg::CMD_RETIRE: begin
        if (cur_valid && !c.busy) begin
          cur_valid = 1'b0;
          if (cur_instant) begin
            slot_full = 1'b0;
            slot = '0;
            s.inst_done = 1'b1;
          end else if (held != 0) begin
            held = held - 5'd1;
          end
          cur_instant = 1'b0;
          cur = '0;
        end
      end
      default: begin
        // Refill poll: arm at or below low water, offer until taken, again after a receive, drop when full.
        if (prog_open && !prog_closed) begin
          if (refill_wanted) begin
            if (held == RING_DEPTH) begin
              refill_wanted = 1'b0;
            end else if (!refill_sent && c.idle) begin
              s.send_req = 1'b1;
              if (c.ok) refill_sent = 1'b1;
            end
          end else if (held <= lw_model) begin
            refill_wanted = 1'b1;
          end
        end else begin
          refill_wanted = 1'b0;
        end
      end
    endcase
    s.valid = cur_valid;
    s.inst = cur_valid && cur_instant;
    s.kind = cur_valid ? cur.kind : 2'd0;
    s.op = cur_valid ? cur.opcode : 4'd0;
    s.pay = cur_valid ? cur.payload : 48'd0;
    s.fill = held;
    s.running = prog_open;
    s.received = prog_closed;
    return s;
  endfunction

  // Random command shaped by traffic mode; mostly well-formed programs.
  function automatic queue_cmd_t random_cmd(traffic_mode_t mode);
    queue_cmd_t c;
    int r;
    int w_recv;
    int w_disp;
    int w_ret;
    case (mode)
      MODE_FILL: begin
        w_recv = 70; w_disp = 80; w_ret = 90;
      end
      MODE_DRAIN: begin
        w_recv = 10; w_disp = 50; w_ret = 90;
      end
      default: begin
        w_recv = 35; w_disp = 60; w_ret = 85;
      end
    endcase
    c.inst = 1'b0;
    c.kind = 2'($urandom_range(0, 3));
    c.op = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 19))
      0: c.pay = '0;
      1: c.pay = ALL_ONES;
      default: c.pay = {16'($urandom), 32'($urandom)};
    endcase
    c.idle = ($urandom_range(0, 3) != 0);
    c.ok = 1'($urandom_range(0, 1));
    c.busy = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 99);
    if (r < w_recv) begin
      c.cmd = ccq_pkg::CMD_RECEIVE;
      if ($urandom_range(0, 6) == 0) begin
        c.inst = 1'b1;
        if ($urandom_range(0, 2) == 0) begin
          c.kind = ccq_pkg::KIND_AUX;
          c.op = ccq_pkg::OP_ABORT;
        end
      end else if (!prog_open && $urandom_range(0, 9) != 0) begin
        c.kind = ccq_pkg::KIND_AUX;
        c.op = ccq_pkg::OP_START;
      end else if (c.kind == ccq_pkg::KIND_AUX) begin
        case ($urandom_range(0, 9))
          0: c.op = ccq_pkg::OP_END;
          1: c.op = ccq_pkg::OP_START;
          2: c.op = ccq_pkg::OP_ABORT;
          default: ;
        endcase
      end
    end else if (r < w_disp) begin
      c.cmd = ccq_pkg::CMD_DISPATCH;
    end else if (r < w_ret) begin
      c.cmd = ccq_pkg::CMD_RETIRE;
    end else begin
      c.cmd = ccq_pkg::CMD_POLL;
    end
    return c;
  endfunction

  function void add_row(queue_cmd_t c, logic fixed = 1'b0, queue_status_t want = '0);
    table_row_t row;
    row.c = c;
    row.fixed = fixed;
    row.want = want;
    stimulus_table.push_back(row);
  endfunction

  // Offers one item, waits for it to be taken, records the expected result, then may idle.
  task automatic send_cmd(queue_cmd_t c, logic fixed, queue_status_t want, logic quiet);
    queue_status_t p;
    int gap;
    int r;
    in_valid <= 1'b1;
    command <= c.cmd;
    instant <= c.inst;
    kind <= c.kind;
    opcode <= c.op;
    payload <= c.pay;
    link_idle <= c.idle;
    send_ok <= c.ok;
    still_busy <= c.busy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = apply_command(c);
    expected_status.push_back(fixed ? want : p);
    gap = 0;
    if (!quiet) begin
      r = $urandom_range(0, 99);
      if (r < 55) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 10);
      else gap = $urandom_range(15, 30);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Writes low_water once the queue has delivered every outstanding result.
  task automatic set_low_water(logic [4:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    lw_model = v;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 5'($urandom_range(0, 31));
  endtask

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Result side: back-pressure with short and long stalls and quiet stretches.
  initial begin : result_backpressure
    int run;
    int len;
    forever begin
      if ($urandom_range(0, 9) == 0) run = $urandom_range(100, 300);
      else run = $urandom_range(0, 12);
      res_stall <= 1'b0;
      repeat (run + 1) @(posedge clk);
      if ($urandom_range(0, 99) < 85) len = $urandom_range(1, 3);
      else len = $urandom_range(8, 40);
      res_stall <= 1'b1;
      repeat (len) @(posedge clk);
    end
  end

  // Each accepted result item is compared with the oldest expectation.
  always @(posedge clk) begin : result_check
    queue_status_t w;
    if (!rst && res_valid && !res_stall) begin
      if (expected_status.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        errors++;
      end else begin
        w = expected_status.pop_front();
        check_field("out_valid", 48'(w.valid), 48'(out_valid));
        check_field("out_instant", 48'(w.inst), 48'(out_instant));
        check_field("out_kind", 48'(w.kind), 48'(out_kind));
        check_field("out_opcode", 48'(w.op), 48'(out_opcode));
        check_field("out_payload", w.pay, out_payload);
        check_field("fill_level", 48'(w.fill), 48'(fill_level));
        check_field("running_flag", 48'(w.running), 48'(running_flag));
        check_field("received_flag", 48'(w.received), 48'(received_flag));
        check_field("send_request", 48'(w.send_req), 48'(send_request));
        check_field("instant_done", 48'(w.inst_done), 48'(instant_done));
        check_field("underflow", 48'(w.under), 48'(underflow));
        check_field("overflow", 48'(w.over), 48'(overflow));
      end
    end
  end

  initial begin : stimulus
    queue_status_t zero_st;
    queue_status_t under_st;
    queue_status_t done_st;
    traffic_mode_t mode;
    logic quiet;
    int count;
    int len;
    logic [4:0] lw;

    zero_st = '0;
    under_st = '0;
    under_st.under = 1'b1;
    done_st = '0;
    done_st.inst_done = 1'b1;

    // Empty-queue behavior straight after reset.
    add_row(make_cmd(ccq_pkg::CMD_DISPATCH, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0), 1'b1, under_st);
    add_row(make_cmd(ccq_pkg::CMD_RETIRE, 0, 2'd0, 4'd0, 48'd0, 1, 1, 0), 1'b1, zero_st);
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 1, 1, 0), 1'b1, zero_st);
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, ccq_pkg::KIND_AUX, ccq_pkg::OP_END, 48'd0,
                     0, 1, 1), 1'b1, zero_st);
    // Instant slot: fill, ignored refill, dispatch, abort while current, busy and normal retire.
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 1, 2'd0, 4'd0, ALL_ONES, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 1, 2'd1, 4'd15, 48'h123, 1, 0, 1));
    add_row(make_cmd(ccq_pkg::CMD_DISPATCH, 0, 2'd3, 4'd9, 48'd7, 0, 1, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 1, ccq_pkg::KIND_AUX, ccq_pkg::OP_ABORT, 48'd0,
                     0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RETIRE, 0, 2'd0, 4'd0, 48'd0, 0, 0, 1));
    add_row(make_cmd(ccq_pkg::CMD_RETIRE, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0), 1'b1, done_st);
    // Abort on an instant slot that is not current.
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 1, 2'd3, 4'd7, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 1, ccq_pkg::KIND_AUX, ccq_pkg::OP_ABORT, 48'h55,
                     0, 0, 0));
    // Program start and the refill request sequence.
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, ccq_pkg::KIND_AUX, ccq_pkg::OP_START,
                     48'hA5A5_5A5A_0F0F, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 1, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 1, 1, 0));
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 1, 1, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, ccq_pkg::KIND_AUX, 4'd15, ALL_ONES, 1, 1, 1));
    // Instant slot wins dispatch; dispatch while current does nothing; ring dispatch.
    add_row(make_cmd(ccq_pkg::CMD_DISPATCH, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_DISPATCH, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RETIRE, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_DISPATCH, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_RETIRE, 0, 2'd0, 4'd0, 48'd0, 0, 0, 0));
    // Program end, poll after close, restart over a closed program.
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, ccq_pkg::KIND_AUX, ccq_pkg::OP_END, 48'h1,
                     0, 0, 0));
    add_row(make_cmd(ccq_pkg::CMD_POLL, 0, 2'd0, 4'd0, 48'd0, 1, 1, 0));
    add_row(make_cmd(ccq_pkg::CMD_RECEIVE, 0, ccq_pkg::KIND_AUX, ccq_pkg::OP_START, 48'd0,
                     0, 0, 0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stimulus_table[i])
      send_cmd(stimulus_table[i].c, stimulus_table[i].fixed, stimulus_table[i].want, 1'b0);

    // Random traffic in phases, each under its own low-water setting.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lw = 5'd0;
        1: lw = 5'd16;
        2: lw = 5'd15;
        3: lw = 5'd1;
        default: lw = 5'($urandom_range(0, 16));
      endcase
      set_low_water(lw);
      count = 0;
      while (count < 265) begin
        mode = traffic_mode_t'($urandom_range(0, 2));
        quiet = ($urandom_range(0, 3) == 0);
        len = $urandom_range(20, 60);
        repeat (len) begin
          send_cmd(random_cmd(mode), 1'b0, '0, quiet);
          count++;
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("cnc_command_queue_tb: done, clean");
    end else begin
      $display("cnc_command_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ccq_pkg.sv
rtl/ccq_ring.sv
rtl/cnc_command_queue.sv
tb/cnc_command_queue_tb.sv
